// ===== rtl/core/amm_pkg.sv =====
// Shared types and codes for the approximate NFA matcher.
// Depends on nothing; amm_ctrl, amm_dp, the top level and the testbench import it.
package amm_pkg;

	localparam logic [2:0] OP_EDGE    = 3'd0;
	localparam logic [2:0] OP_CLASS   = 3'd1;
	localparam logic [2:0] OP_ACCEPT  = 3'd2;
	localparam logic [2:0] OP_STEP    = 3'd3;
	localparam logic [2:0] OP_RESTART = 3'd4;

	localparam logic [2:0] KIND_UNUSED = 3'd0;
	localparam logic [2:0] KIND_LIT    = 3'd1;
	localparam logic [2:0] KIND_ANY    = 3'd2;
	localparam logic [2:0] KIND_CLASS  = 3'd3;
	localparam logic [2:0] KIND_EPS    = 3'd4;

	localparam logic REG_START  = 1'b0;
	localparam logic REG_BUDGET = 1'b1;

	typedef struct packed {
		logic [3:0] src;
		logic [3:0] dst;
		logic [2:0] kind;
		logic [7:0] lit;
		logic [1:0] cls;
	} edge_t;

	typedef struct packed {
		logic load;
		logic clr_next;
		logic start_wr;
		logic edge_clr;
		logic edge_inc;
		logic edge_rd;
		logic rd_sym;
		logic rd_eps;
		logic rd_rep;
		logic sym_upd;
		logic eps_upd;
		logic round_clr;
		logic round_inc;
		logic changed_clr;
		logic flip;
		logic st_clr;
		logic st_inc;
		logic rep_clr;
		logic rep_acc;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic edge_last;
		logic st_last;
		logic round_last;
		logic changed;
		logic out_busy;
	} ctl_sts_t;

endpackage

// ===== rtl/core/amm_if.sv =====
// Channel interfaces of the matcher: input items, result items, configuration writes.
// Stand-alone; no package needed.
interface amm_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [5:0]  edge_slot;
	logic [3:0]  edge_source;
	logic [3:0]  edge_target;
	logic [2:0]  edge_kind;
	logic [7:0]  edge_char;
	logic [1:0]  edge_class_id;
	logic [3:0]  class_word_slot;
	logic [63:0] class_bits;
	logic [15:0] accept_bits;
	logic [7:0]  text_byte;
	modport source (output valid, op, edge_slot, edge_source, edge_target, edge_kind,
		edge_char, edge_class_id, class_word_slot, class_bits, accept_bits, text_byte,
		input ready);
	modport sink (input valid, op, edge_slot, edge_source, edge_target, edge_kind,
		edge_char, edge_class_id, class_word_slot, class_bits, accept_bits, text_byte,
		output ready);
endinterface

interface amm_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] live_states;
	logic       is_accepting;
	logic [4:0] least_mismatch;
	modport source (output valid, live_states, is_accepting, least_mismatch, input ready);
	modport sink (input valid, live_states, is_accepting, least_mismatch, output ready);
endinterface

interface amm_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [3:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/amm_ctrl.sv =====
// Sequencer of the matcher: symbol pass, epsilon rounds, report sweep and result hand-off.
// Depends on amm_pkg for the command and status structs and the op codes.
module amm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         in_op,
	output logic               in_ready,
	output amm_pkg::ctl_cmd_t  cmd,
	input  amm_pkg::ctl_sts_t  sts
);
	import amm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_SA   = 4'd2;
	localparam logic [3:0] ST_SB   = 4'd3;
	localparam logic [3:0] ST_SC   = 4'd4;
	localparam logic [3:0] ST_EA   = 4'd5;
	localparam logic [3:0] ST_EB   = 4'd6;
	localparam logic [3:0] ST_EC   = 4'd7;
	localparam logic [3:0] ST_RA   = 4'd8;
	localparam logic [3:0] ST_RB   = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] state_q, state_d;
	logic       restart_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_op == OP_STEP || in_op == OP_RESTART) begin
						state_d = ST_CLR;
					end
				end
			end
			ST_CLR: begin
				cmd.clr_next    = 1'b1;
				cmd.start_wr    = restart_q;
				cmd.edge_clr    = 1'b1;
				cmd.round_clr   = 1'b1;
				cmd.changed_clr = 1'b1;
				state_d = restart_q ? ST_EA : ST_SA;
			end
			ST_SA: begin
				cmd.edge_rd = 1'b1;
				state_d = ST_SB;
			end
			ST_SB: begin
				cmd.rd_sym = 1'b1;
				state_d = ST_SC;
			end
			ST_SC: begin
				cmd.sym_upd = 1'b1;
				if (sts.edge_last) begin
					cmd.edge_clr = 1'b1;
					state_d = ST_EA;
				end else begin
					cmd.edge_inc = 1'b1;
					state_d = ST_SA;
				end
			end
			ST_EA: begin
				cmd.edge_rd = 1'b1;
				state_d = ST_EB;
			end
			ST_EB: begin
				cmd.rd_eps = 1'b1;
				state_d = ST_EC;
			end
			ST_EC: begin
				cmd.eps_upd = 1'b1;
				if (!sts.edge_last) begin
					cmd.edge_inc = 1'b1;
					state_d = ST_EA;
				end else if (sts.changed && !sts.round_last) begin
					cmd.edge_clr    = 1'b1;
					cmd.round_inc   = 1'b1;
					cmd.changed_clr = 1'b1;
					state_d = ST_EA;
				end else begin
					cmd.flip    = 1'b1;
					cmd.st_clr  = 1'b1;
					cmd.rep_clr = 1'b1;
					state_d = ST_RA;
				end
			end
			ST_RA: begin
				cmd.rd_rep = 1'b1;
				state_d = ST_RB;
			end
			ST_RB: begin
				cmd.rep_acc = 1'b1;
				if (sts.st_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.st_inc = 1'b1;
					state_d = ST_RA;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				restart_q <= (in_op == OP_RESTART);
			end
		end
	end

endmodule

// ===== rtl/core/amm_dp.sv =====
// Datapath of the matcher: edge, class and cost memories, relaxation and report logic.
// Depends on amm_pkg; driven by amm_ctrl through command and status structs.
module amm_dp #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_EDGES   = 64,
	parameter int NUM_CLASSES = 4,
	parameter int MAX_BUDGET  = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  amm_pkg::ctl_cmd_t  cmd,
	output amm_pkg::ctl_sts_t  sts,
	input  logic [2:0]         op,
	input  logic [5:0]         edge_slot,
	input  logic [3:0]         edge_source,
	input  logic [3:0]         edge_target,
	input  logic [2:0]         edge_kind,
	input  logic [7:0]         edge_char,
	input  logic [1:0]         edge_class_id,
	input  logic [3:0]         class_word_slot,
	input  logic [63:0]        class_bits,
	input  logic [15:0]        accept_bits,
	input  logic [7:0]         text_byte,
	input  logic               cfg_valid,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	output logic               cfg_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         live_states,
	output logic               is_accepting,
	output logic [4:0]         least_mismatch
);
	import amm_pkg::*;

	localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int EW  = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
	localparam int CWN = NUM_CLASSES * 4;
	localparam int CW  = $clog2(CWN);
	localparam int CBW = $clog2(MAX_BUDGET + 2);
	localparam int CD  = 2 * (2 ** SW);
	localparam int LW  = $clog2(NUM_STATES + 1);
	localparam logic [CBW-1:0] DEAD = CBW'(MAX_BUDGET + 1);

	edge_t             edge_mem [NUM_EDGES];
	logic [NUM_EDGES-1:0] edge_vld_q;
	logic [63:0]       cls_mem [CWN];
	logic [CBW-1:0]    cost_mem [CD];
	logic [CD-1:0]     cost_vld_q;

	logic [15:0]       accept_q;
	logic [3:0]        start_q, budget_reg_q;
	logic [7:0]        sym_q;
	logic              bank_q;
	logic [EW-1:0]     edge_cnt_q;
	logic [SW-1:0]     st_cnt_q, round_q;
	logic              changed_q;

	edge_t             edge_s1;
	logic              edge_v_s1;
	logic [CBW-1:0]    cost_a_s2, cost_b_s2;
	logic              cost_av_s2, cost_bv_s2;
	logic [63:0]       cls_word_s2;

	logic [LW-1:0]     live_q;
	logic              acc_q;
	logic [CBW-1:0]    best_q;

	edge_t             e;
	logic              src_ok, dst_ok, start_ok, hit;
	logic [SW-1:0]     src_i, dst_i, start_i;
	logic [CBW-1:0]    budget, ca, cb;
	logic [CBW:0]      c_inc;
	logic              sym_wr, eps_wr;
	logic [SW:0]       addr_a, addr_b;
	logic              cur, nxt;

	assign cur = bank_q;
	assign nxt = ~bank_q;

	assign budget = (int'(budget_reg_q) > MAX_BUDGET) ? CBW'(MAX_BUDGET) : CBW'(budget_reg_q);

	// An entry never written reads as an unused edge.
	assign e        = edge_v_s1 ? edge_s1 : '0;
	assign src_ok   = int'(e.src) < NUM_STATES;
	assign dst_ok   = int'(e.dst) < NUM_STATES;
	assign src_i    = SW'(e.src);
	assign dst_i    = SW'(e.dst);
	assign start_ok = int'(start_q) < NUM_STATES;
	assign start_i  = SW'(start_q);

	assign addr_a = cmd.rd_rep ? {cur, st_cnt_q} : (cmd.rd_sym ? {cur, src_i} : {nxt, src_i});
	assign addr_b = {nxt, dst_i};

	assign ca = cost_av_s2 ? cost_a_s2 : DEAD;
	assign cb = cost_bv_s2 ? cost_b_s2 : DEAD;

	always_comb begin
		case (e.kind)
			KIND_LIT:   hit = (e.lit == sym_q);
			KIND_ANY:   hit = 1'b1;
			KIND_CLASS: hit = (int'(e.cls) < NUM_CLASSES) && cls_word_s2[sym_q[5:0]];
			default:    hit = 1'b0;
		endcase
	end

	assign c_inc  = {1'b0, ca} + {{CBW{1'b0}}, ~hit};
	assign sym_wr = cmd.sym_upd && (e.kind == KIND_LIT || e.kind == KIND_ANY ||
		e.kind == KIND_CLASS) && src_ok && dst_ok && (ca <= budget) &&
		(c_inc <= {1'b0, budget}) && (c_inc < {1'b0, cb});
	assign eps_wr = cmd.eps_upd && (e.kind == KIND_EPS) && src_ok && dst_ok &&
		(ca <= budget) && (ca < cb);

	// Memories: edge table, class words and the two banks of costs.
	always_ff @(posedge clk) begin
		if (cmd.load && op == OP_EDGE && int'(edge_slot) < NUM_EDGES) begin
			edge_mem[EW'(edge_slot)] <= '{src: edge_source, dst: edge_target,
				kind: edge_kind, lit: edge_char, cls: edge_class_id};
		end
		if (cmd.edge_rd) begin
			edge_s1 <= edge_mem[edge_cnt_q];
		end
		if (cmd.load && op == OP_CLASS && int'(class_word_slot) < CWN) begin
			cls_mem[CW'(class_word_slot)] <= class_bits;
		end
		if (cmd.rd_sym) begin
			cls_word_s2 <= cls_mem[CW'({e.cls, sym_q[7:6]})];
		end
		if (cmd.start_wr && start_ok) begin
			cost_mem[{nxt, start_i}] <= '0;
		end else if (sym_wr) begin
			cost_mem[addr_b] <= c_inc[CBW-1:0];
		end else if (eps_wr) begin
			cost_mem[addr_b] <= ca;
		end
		if (cmd.rd_sym || cmd.rd_eps || cmd.rd_rep) begin
			cost_a_s2 <= cost_mem[addr_a];
			cost_b_s2 <= cost_mem[addr_b];
		end
		if (cmd.load) begin
			sym_q <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_vld_q   <= '0;
			cost_vld_q   <= '0;
			edge_v_s1    <= 1'b0;
			cost_av_s2   <= 1'b0;
			cost_bv_s2   <= 1'b0;
			accept_q     <= '0;
			start_q      <= '0;
			budget_reg_q <= '0;
			bank_q       <= 1'b0;
			edge_cnt_q   <= '0;
			st_cnt_q     <= '0;
			round_q      <= '0;
			changed_q    <= 1'b0;
			live_q       <= '0;
			acc_q        <= 1'b0;
			best_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.load && op == OP_EDGE && int'(edge_slot) < NUM_EDGES) begin
				edge_vld_q[EW'(edge_slot)] <= 1'b1;
			end
			if (cmd.load && op == OP_ACCEPT) begin
				accept_q <= accept_bits;
			end
			if (cmd.edge_rd) begin
				edge_v_s1 <= edge_vld_q[edge_cnt_q];
			end
			if (cmd.rd_sym || cmd.rd_eps || cmd.rd_rep) begin
				cost_av_s2 <= cost_vld_q[addr_a];
				cost_bv_s2 <= cost_vld_q[addr_b];
			end
			// Clearing the valid bits of the next bank marks all its states dead; a restart
			// marks its start state live in the same pass.
			if (cmd.clr_next) begin
				for (int i = 0; i < CD; i++) begin
					if ((i >= CD / 2) == nxt) begin
						cost_vld_q[i] <= cmd.start_wr && start_ok &&
							(i == int'({nxt, start_i}));
					end
				end
			end else if (sym_wr || eps_wr) begin
				cost_vld_q[addr_b] <= 1'b1;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_START:  start_q      <= cfg_data;
					REG_BUDGET: budget_reg_q <= cfg_data;
				endcase
			end
			if (cmd.flip) begin
				bank_q <= ~bank_q;
			end
			if (cmd.edge_clr) begin
				edge_cnt_q <= '0;
			end else if (cmd.edge_inc) begin
				edge_cnt_q <= edge_cnt_q + 1'b1;
			end
			if (cmd.st_clr) begin
				st_cnt_q <= '0;
			end else if (cmd.st_inc) begin
				st_cnt_q <= st_cnt_q + 1'b1;
			end
			if (cmd.round_clr) begin
				round_q <= '0;
			end else if (cmd.round_inc) begin
				round_q <= round_q + 1'b1;
			end
			if (cmd.changed_clr) begin
				changed_q <= 1'b0;
			end else if (eps_wr) begin
				changed_q <= 1'b1;
			end
			if (cmd.rep_clr) begin
				live_q <= '0;
				acc_q  <= 1'b0;
				best_q <= budget + 1'b1;
			end else if (cmd.rep_acc && ca <= budget) begin
				live_q <= live_q + 1'b1;
				if (int'(st_cnt_q) < 16 && accept_q[4'(st_cnt_q)]) begin
					acc_q <= 1'b1;
				end
				if (ca < best_q) begin
					best_q <= ca;
				end
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			live_states    <= 5'(live_q);
			is_accepting   <= acc_q;
			least_mismatch <= 5'(best_q);
		end
	end

	assign cfg_ready = 1'b1;

	assign sts.edge_last  = (edge_cnt_q == EW'(NUM_EDGES - 1));
	assign sts.st_last    = (st_cnt_q == SW'(NUM_STATES - 1));
	assign sts.round_last = (round_q == SW'(NUM_STATES - 1));
	assign sts.changed    = changed_q | eps_wr;
	assign sts.out_busy   = out_valid & ~out_ready;

endmodule

// ===== rtl/core/approx_nfa_mismatch_matcher.sv =====
// Approximate NFA matcher with a mismatch budget, top level.
// Loads are taken in idle. A step runs a symbol pass over every edge, R epsilon rounds over every
// edge (R from 1 to NUM_STATES) and a report sweep over the states; a restart seeds the start
// state and skips the symbol pass. Edges go one at a time through the single table and cost ports.
// One item is in work at a time; the result waits in an output register.
// Reset clears costs (all dead), edges (unused), accept flags and configuration at once.
module approx_nfa_mismatch_matcher #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_EDGES   = 64,
	parameter int NUM_CLASSES = 4,
	parameter int MAX_BUDGET  = 15
) (
	input logic          clk,
	input logic          arst_n,
	amm_item_if.sink     item_in,
	amm_result_if.source result_out,
	amm_cfg_if.sink      cfg
);
	import amm_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	amm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_op    (item_in.op),
		.in_ready (item_in.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	amm_dp #(
		.NUM_STATES  (NUM_STATES),
		.NUM_EDGES   (NUM_EDGES),
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_BUDGET  (MAX_BUDGET)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.op              (item_in.op),
		.edge_slot       (item_in.edge_slot),
		.edge_source     (item_in.edge_source),
		.edge_target     (item_in.edge_target),
		.edge_kind       (item_in.edge_kind),
		.edge_char       (item_in.edge_char),
		.edge_class_id   (item_in.edge_class_id),
		.class_word_slot (item_in.class_word_slot),
		.class_bits      (item_in.class_bits),
		.accept_bits     (item_in.accept_bits),
		.text_byte       (item_in.text_byte),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.cfg_ready       (cfg.ready),
		.out_valid       (result_out.valid),
		.out_ready       (result_out.ready),
		.live_states     (result_out.live_states),
		.is_accepting    (result_out.is_accepting),
		.least_mismatch  (result_out.least_mismatch)
	);

endmodule

// ===== tb/approx_nfa_mismatch_matcher_test.sv =====
// Testbench for approx_nfa_mismatch_matcher: directed and random item streams, checked
// against a predictor of the automaton kept in this file. Needs amm_pkg and the channel
// interfaces of the block.
module approx_nfa_mismatch_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;
	import amm_pkg::*;

	localparam int N_ST = 16;
	localparam int N_ED = 64;
	localparam int N_WORDS = 16;
	localparam int DRAIN_CYCLES = 3500;
	localparam int STALL_LIMIT = 40000;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  slot;
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [2:0]  kind;
		logic [7:0]  lit;
		logic [1:0]  cls;
		logic [3:0]  word_slot;
		logic [63:0] bits;
		logic [15:0] acc;
		logic [7:0]  sym;
	} matcher_item_t;

	typedef struct packed {
		logic [4:0] live;
		logic       accepting;
		logic [4:0] least;
	} match_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	amm_item_if   item_in();
	amm_result_if result_out();
	amm_cfg_if    cfg();

	approx_nfa_mismatch_matcher u_dut (
		.clk(clk), .arst_n(arst_n), .item_in(item_in), .result_out(result_out), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// Predicted state of the automaton.
	logic [4:0]  cost_now [N_ST];
	edge_t       edge_mem [N_ED];
	logic [63:0] class_mem [N_WORDS];
	logic [15:0] accept_mask;
	logic [3:0]  start_reg;
	logic [3:0]  budget_reg;

	match_report_t report_q[$];
	int errors = 0;
	bit gaps_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	logic [7:0] alphabet [4];

	function automatic void relax_epsilon(ref logic [4:0] c [N_ST]);
		bit changed;
		changed = 1'b1;
		for (int r = 0; r < N_ST && changed; r++) begin
			changed = 1'b0;
			foreach (edge_mem[i]) begin
				if (edge_mem[i].kind == KIND_EPS && c[edge_mem[i].src] <= budget_reg &&
						c[edge_mem[i].src] < c[edge_mem[i].dst]) begin
					c[edge_mem[i].dst] = c[edge_mem[i].src];
					changed = 1'b1;
				end
			end
		end
	endfunction

	function automatic match_report_t summarise();
		match_report_t r;
		r.live = '0;
		r.accepting = 1'b0;
		r.least = budget_reg + 5'd1;
		for (int i = 0; i < N_ST; i++) begin
			if (cost_now[i] <= budget_reg) begin
				r.live++;
				if (accept_mask[i]) r.accepting = 1'b1;
				if (cost_now[i] < r.least) r.least = cost_now[i];
			end
		end
		return r;
	endfunction

	function automatic void apply_item(matcher_item_t it);
		logic [4:0] next [N_ST];
		logic [4:0] c;
		bit hit;
		case (it.op)
			OP_EDGE: edge_mem[it.slot] = '{src: it.src, dst: it.dst, kind: it.kind,
				lit: it.lit, cls: it.cls};
			OP_CLASS: class_mem[it.word_slot] = it.bits;
			OP_ACCEPT: accept_mask = it.acc;
			OP_STEP: begin
				foreach (next[i]) next[i] = 5'd16;
				foreach (edge_mem[i]) begin
					if (edge_mem[i].kind inside {KIND_LIT, KIND_ANY, KIND_CLASS}) begin
						c = cost_now[edge_mem[i].src];
						if (c <= budget_reg) begin
							case (edge_mem[i].kind)
								KIND_LIT: hit = edge_mem[i].lit == it.sym;
								KIND_ANY: hit = 1'b1;
								default: hit = class_mem[{edge_mem[i].cls, it.sym[7:6]}][it.sym[5:0]];
							endcase
							if (!hit) c++;
							if (c <= budget_reg && c < next[edge_mem[i].dst])
								next[edge_mem[i].dst] = c;
						end
					end
				end
				relax_epsilon(next);
				cost_now = next;
				report_q = {report_q, summarise()};
			end
			OP_RESTART: begin
				foreach (cost_now[i]) cost_now[i] = 5'd16;
				cost_now[start_reg] = 5'd0;
				relax_epsilon(cost_now);
				report_q = {report_q, summarise()};
			end
			default: ;
		endcase
	endfunction

	// Items are driven from a falling edge; acceptance is seen at the rising edge.
	task automatic send_item(matcher_item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_in.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_in.op = it.op;
		item_in.edge_slot = it.slot;
		item_in.edge_source = it.src;
		item_in.edge_target = it.dst;
		item_in.edge_kind = it.kind;
		item_in.edge_char = it.lit;
		item_in.edge_class_id = it.cls;
		item_in.class_word_slot = it.word_slot;
		item_in.class_bits = it.bits;
		item_in.accept_bits = it.acc;
		item_in.text_byte = it.sym;
		item_in.valid = 1'b1;
		do @(posedge clk); while (!item_in.ready);
		apply_item(it);
		@(negedge clk);
		item_in.valid = 1'b0;
	endtask

	task automatic write_reg(logic index, logic [3:0] value);
		cfg.index = index;
		cfg.data = value;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		if (index == REG_START) start_reg = value;
		else budget_reg = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (report_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic matcher_item_t noise_item();
		matcher_item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(matcher_item_t)-1:0];
		it.bits = {$urandom, $urandom};
		return it;
	endfunction

	function automatic matcher_item_t edge_item(int slot, int src, int dst, logic [2:0] kind,
			int lit, int cls);
		matcher_item_t it;
		it = noise_item();
		it.op = OP_EDGE;
		it.slot = 6'(slot);
		it.src = 4'(src);
		it.dst = 4'(dst);
		it.kind = kind;
		it.lit = 8'(lit);
		it.cls = 2'(cls);
		return it;
	endfunction

	function automatic matcher_item_t op_item(logic [2:0] op, int sym);
		matcher_item_t it;
		it = noise_item();
		it.op = op;
		it.sym = 8'(sym);
		return it;
	endfunction

	function automatic matcher_item_t accept_item(logic [15:0] mask);
		matcher_item_t it;
		it = op_item(OP_ACCEPT, 0);
		it.acc = mask;
		return it;
	endfunction

	function automatic matcher_item_t class_item(int word, logic [63:0] bits);
		matcher_item_t it;
		it = op_item(OP_CLASS, 0);
		it.word_slot = 4'(word);
		it.bits = bits;
		return it;
	endfunction

	// A step before any restart must report no live state.
	task automatic test_cold_step();
		send_item(op_item(OP_STEP, 8'h00));
	endtask

	// Every class word is written before any class edge exists.
	task automatic test_class_load();
		for (int w = 0; w < N_WORDS; w++)
			send_item(class_item(w, w == 0 ? 64'd0 : w == 1 ? '1 : {$urandom, $urandom}));
	endtask

	task automatic test_directed();
		write_reg(REG_START, 4'd0);
		write_reg(REG_BUDGET, 4'd0);
		send_item(edge_item(0, 0, 1, KIND_LIT, 8'h61, 0));
		send_item(edge_item(63, 1, 2, KIND_ANY, 8'hff, 3));
		send_item(edge_item(10, 2, 3, KIND_CLASS, 0, 3));
		send_item(edge_item(11, 3, 15, KIND_EPS, 0, 0));
		send_item(edge_item(12, 15, 0, 3'd7, 8'h61, 0));
		send_item(accept_item(16'h8000));
		send_item(op_item(OP_RESTART, 0));
		send_item(op_item(OP_STEP, 8'h61));
		send_item(op_item(OP_STEP, 8'hff));
		// The sender holds off until the block has answered everything.
		while (report_q.size() != 0) @(negedge clk);
		send_item(op_item(OP_STEP, 8'h00));
		send_item(op_item(OP_STEP, 8'h62));
		send_item(op_item(3'd5, 0));
		send_item(op_item(3'd7, 0));
		wait_idle();
		write_reg(REG_BUDGET, 4'd15);
		write_reg(REG_START, 4'd15);
		send_item(accept_item(16'hffff));
		send_item(op_item(OP_RESTART, 0));
		send_item(op_item(OP_STEP, 8'h62));
		wait_idle();
		write_reg(REG_START, 4'd0);
		send_item(op_item(OP_RESTART, 0));
		send_item(op_item(OP_STEP, 8'h62));
		wait_idle();
		// Budget lowered between steps: stored costs are judged against the new budget.
		write_reg(REG_BUDGET, 4'd0);
		send_item(op_item(OP_STEP, 8'h61));
	endtask

	function automatic logic [2:0] pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 6) return KIND_LIT;
		if (r < 9) return KIND_ANY;
		if (r < 12) return KIND_CLASS;
		if (r < 17) return KIND_EPS;
		if (r < 18) return KIND_UNUSED;
		return 3'($urandom_range(5, 7));
	endfunction

	function automatic int pick_state(int span);
		return $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(0, span);
	endfunction

	task automatic test_random(int phases);
		int span, steps, r;
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			if (p == phases - 1) gaps_on = 1'b0;
			write_reg(REG_START, p % 5 == 1 ? 4'd15 : 4'($urandom_range(0, 3)));
			write_reg(REG_BUDGET, p % 4 == 0 ? 4'd0 : p % 4 == 1 ? 4'd15 :
				4'($urandom_range(1, 4)));
			span = $urandom_range(3, 15);
			foreach (alphabet[i]) alphabet[i] = 8'($urandom);
			for (int e = 0; e < 14; e++)
				send_item(edge_item($urandom_range(0, 63), pick_state(span), pick_state(span),
					pick_kind(), alphabet[$urandom_range(0, 3)], $urandom_range(0, 3)));
			if ($urandom_range(0, 1)) send_item(class_item($urandom_range(0, 15),
				{$urandom, $urandom}));
			send_item(accept_item(16'($urandom)));
			send_item(op_item(OP_RESTART, 0));
			steps = $urandom_range(10, 20);
			for (int s = 0; s < steps; s++) begin
				r = $urandom_range(0, 19);
				if (r == 0) send_item(noise_item());
				else if (r == 1) send_item(op_item(OP_RESTART, 0));
				else if (r == 2) send_item(edge_item($urandom_range(0, 63), pick_state(span),
					pick_state(span), pick_kind(), alphabet[$urandom_range(0, 3)],
					$urandom_range(0, 3)));
				else send_item(op_item(OP_STEP, $urandom_range(0, 2) == 0 ? $urandom_range(0, 255)
					: alphabet[$urandom_range(0, 3)]));
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_out.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			result_out.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			result_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		match_report_t want, got;
		if (result_out.valid && result_out.ready) begin
			got = '{result_out.live_states, result_out.is_accepting, result_out.least_mismatch};
			if (report_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: %p", got);
			end else begin
				want = report_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_in.valid && item_in.ready) || (result_out.valid && result_out.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL approx_nfa_mismatch_matcher");
			$finish;
		end
	end

	initial begin
		item_in.valid = 1'b0;
		item_in.op = '0;
		item_in.edge_slot = '0;
		item_in.edge_source = '0;
		item_in.edge_target = '0;
		item_in.edge_kind = '0;
		item_in.edge_char = '0;
		item_in.edge_class_id = '0;
		item_in.class_word_slot = '0;
		item_in.class_bits = '0;
		item_in.accept_bits = '0;
		item_in.text_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = 1'b0;
		cfg.data = '0;
		foreach (cost_now[i]) cost_now[i] = 5'd16;
		foreach (edge_mem[i]) edge_mem[i] = '0;
		foreach (class_mem[i]) class_mem[i] = '0;
		accept_mask = '0;
		start_reg = '0;
		budget_reg = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_cold_step();
		test_class_load();
		test_directed();
		test_random(18);
		wait_idle();
		if (errors == 0 && report_q.size() == 0)
			$display("PASS approx_nfa_mismatch_matcher");
		else
			$display("FAIL approx_nfa_mismatch_matcher");
		$finish;
	end
endmodule
